>>> rtl/core/assert_macros.svh
// assertion helpers shared by the rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef NO_ASSERTIONS
// checked property, masked while reset is held
`define CMH_ASSERT(name, prop, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);
// checked property, also during reset
`define CMH_ASSERT_ALWAYS(name, prop, msg) \
  name: assert property (@(posedge clk_i) prop) else $error(msg);
`else
`define CMH_ASSERT(name, prop, msg)
`define CMH_ASSERT_ALWAYS(name, prop, msg)
`endif

`endif

>>> rtl/core/cmh_pkg.sv
package cmh_pkg;

  // hash constants
  localparam logic [31:0] HASH_SEED  = 32'd5381;
  localparam int unsigned HASH_SHIFT = 5;

  // request codes
  typedef enum logic [1:0] {
    OP_GET    = 2'd0,
    OP_SET    = 2'd1,
    OP_REMOVE = 2'd2
  } op_e;

  // result codes
  typedef enum logic [1:0] {
    STAT_OK        = 2'd0,
    STAT_NOT_FOUND = 2'd1,
    STAT_FULL      = 2'd2
  } status_e;

  // start request to the hash unit
  typedef struct packed {
    logic       start;
    logic [3:0] len;
  } hash_req_t;

  // length of text up to the first zero byte, capped at n and at eight
  function automatic logic [3:0] text_len(logic [63:0] v, logic [3:0] n);
    logic [3:0] lim;
    logic [3:0] cnt;
    logic       stop;
    lim  = (n > 4'd8) ? 4'd8 : n;
    cnt  = 4'd0;
    stop = 1'b0;
    for (int i = 0; i < 8; i++) begin
      if (!stop && (4'(i) < lim) && (v[8*i +: 8] != 8'h00)) begin
        cnt = cnt + 4'd1;
      end else begin
        stop = 1'b1;
      end
    end
    return cnt;
  endfunction

  // keep the low n bytes, zero the rest
  function automatic logic [63:0] low_bytes(logic [63:0] v, logic [3:0] n);
    logic [63:0] r;
    r = v;
    for (int i = 0; i < 8; i++) begin
      if (4'(i) >= n) begin
        r[8*i +: 8] = 8'h00;
      end
    end
    return r;
  endfunction

endpackage

>>> rtl/core/cmh_ram.sv
module cmh_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 256
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  // registered read port
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_o <= mem[raddr_i];
    end
  end

endmodule

>>> rtl/core/cmh_hash.sv
module cmh_hash (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  cmh_pkg::hash_req_t req_i,
  input  logic [63:0]        key_i,
  output logic               done_o,
  output logic [31:0]        hash_o
);

  import cmh_pkg::*;

  logic        busy_q, busy_d;
  logic [3:0]  cnt_q, cnt_d;
  logic [3:0]  len_q, len_d;
  logic [63:0] key_q, key_d;
  logic [31:0] h_q, h_d;

  // one key byte per cycle: h = h*33 xor byte
  always_comb begin
    busy_d = busy_q;
    cnt_d  = cnt_q;
    len_d  = len_q;
    key_d  = key_q;
    h_d    = h_q;
    if (req_i.start) begin
      busy_d = 1'b1;
      cnt_d  = 4'd0;
      len_d  = req_i.len;
      key_d  = key_i;
      h_d    = HASH_SEED;
    end else if (busy_q) begin
      if (cnt_q < len_q) begin
        h_d   = ((h_q << HASH_SHIFT) + h_q) ^ {24'd0, key_q[{cnt_q[2:0], 3'b000} +: 8]};
        cnt_d = cnt_q + 4'd1;
      end else begin
        busy_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= 4'd0;
      len_q  <= 4'd0;
      key_q  <= 64'd0;
      h_q    <= 32'd0;
    end else begin
      busy_q <= busy_d;
      cnt_q  <= cnt_d;
      len_q  <= len_d;
      key_q  <= key_d;
      h_q    <= h_d;
    end
  end

  assign done_o = busy_q && (cnt_q >= len_q);
  assign hash_o = h_q;

endmodule

>>> rtl/core/chained_hash_map_engine_top.sv
// Key/value table with one chain per bucket (ENTRIES must be a power of two).
// One item at a time: the key is hashed a byte at a time, the bucket head is
// read, the chain is walked entry by entry through the entry memory's single
// read port, and a get or set then ends with a decision step and a result
// step (a new key linked in front of an existing chain adds a write to the old
// head). A remove adds read-modify-write steps on the entry memory to unlink
// the entry and move the last pool entry into the hole. After reset a clearing
// pass empties the bucket heads, during which no item is accepted;
// value_max_bytes can be written at any idle time.
module chained_hash_map_engine_top #(
  parameter int unsigned ENTRIES   = 256,
  parameter int unsigned KEY_BYTES = 8
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [3:0]  cfg_wdata_i,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [1:0]  operation_i,
  input  logic [63:0] key_bytes_i,
  input  logic [3:0]  key_length_i,
  input  logic [63:0] value_bytes_i,
  input  logic [3:0]  value_length_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [1:0]  status_o,
  output logic [63:0] found_value_o,
  output logic [3:0]  found_length_o
);

  import cmh_pkg::*;

  localparam int unsigned IW = $clog2(ENTRIES);
  localparam int unsigned UW = IW + 1;
  localparam int unsigned KW = 8 * KEY_BYTES;

  typedef struct packed {
    logic [31:0]   hash;
    logic [KW-1:0] key;
    logic [63:0]   value;
    logic [IW-1:0] prev;
    logic          prev_ok;
    logic [IW-1:0] next;
    logic          next_ok;
  } entry_t;

  typedef struct packed {
    logic          ok;
    logic [IW-1:0] idx;
  } head_t;

  typedef enum logic [4:0] {
    S_CLEAR, S_IDLE, S_HASH, S_HEAD_WT, S_WALK, S_DECIDE, S_SET_OLD_WR,
    S_RM_PREV_WR, S_RM_NEXT_RD, S_RM_NEXT_WR, S_RM_HEAD, S_RM_LAST_WR,
    S_RM_LP_RD, S_RM_LP_WR, S_RM_LN_RD, S_RM_LN_WR, S_RM_LH_RD, S_RM_LH_WR,
    S_DONE
  } state_e;

  state_e        state_q, state_d;
  logic [IW-1:0] clr_q, clr_d;
  logic [3:0]    vmax_q;
  logic [1:0]    op_q, op_d;
  logic [63:0]   key_q, key_d;
  logic [3:0]    klen_q, klen_d;
  logic [63:0]   val_q, val_d;
  logic [31:0]   hash_q, hash_d;
  head_t         head_q, head_d;
  logic [IW-1:0] cur_q, cur_d;
  entry_t        rec_q, rec_d;
  entry_t        lrec_q, lrec_d;
  logic          hit_q, hit_d;
  logic [UW-1:0] used_q, used_d;
  logic [1:0]    res_status_q, res_status_d;
  logic [63:0]   res_value_q, res_value_d;
  logic [3:0]    res_len_q, res_len_d;
  logic          out_valid_q, out_valid_d;
  logic [1:0]    out_status_q, out_status_d;
  logic [63:0]   out_value_q, out_value_d;
  logic [3:0]    out_len_q, out_len_d;

  // memory ports
  logic          head_we, head_re;
  logic [IW-1:0] head_waddr, head_raddr;
  head_t         head_wdata, head_rdata;
  logic          ent_we, ent_re;
  logic [IW-1:0] ent_waddr, ent_raddr;
  entry_t        ent_wdata, ent_rdata;

  // hash unit
  hash_req_t     hash_req;
  logic [63:0]   hash_key;
  logic          hash_done;
  logic [31:0]   hash_val;

  cmh_hash u_hash (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (hash_req),
    .key_i  (hash_key),
    .done_o (hash_done),
    .hash_o (hash_val)
  );

  cmh_ram #(.WIDTH($bits(head_t)), .DEPTH(ENTRIES)) u_head_ram (
    .clk_i   (clk_i),
    .we_i    (head_we),
    .waddr_i (head_waddr),
    .wdata_i (head_wdata),
    .re_i    (head_re),
    .raddr_i (head_raddr),
    .rdata_o (head_rdata)
  );

  cmh_ram #(.WIDTH($bits(entry_t)), .DEPTH(ENTRIES)) u_entry_ram (
    .clk_i   (clk_i),
    .we_i    (ent_we),
    .waddr_i (ent_waddr),
    .wdata_i (ent_wdata),
    .re_i    (ent_re),
    .raddr_i (ent_raddr),
    .rdata_o (ent_rdata)
  );

  // request sequencer
  always_comb begin
    logic [3:0] kl;
    logic [3:0] vl;
    logic [3:0] vmax;
    entry_t     nw;
    kl   = text_len(key_bytes_i, key_length_i);
    vmax = (vmax_q > 4'd8) ? 4'd8 : vmax_q;
    vl   = text_len(value_bytes_i, value_length_i);
    if (vl > vmax) begin
      vl = vmax;
    end
    nw = '0;

    state_d      = state_q;
    clr_d        = clr_q;
    op_d         = op_q;
    key_d        = key_q;
    klen_d       = klen_q;
    val_d        = val_q;
    hash_d       = hash_q;
    head_d       = head_q;
    cur_d        = cur_q;
    rec_d        = rec_q;
    lrec_d       = lrec_q;
    hit_d        = hit_q;
    used_d       = used_q;
    res_status_d = res_status_q;
    res_value_d  = res_value_q;
    res_len_d    = res_len_q;
    out_valid_d  = out_valid_q;
    out_status_d = out_status_q;
    out_value_d  = out_value_q;
    out_len_d    = out_len_q;

    head_we    = 1'b0;
    head_waddr = '0;
    head_wdata = '0;
    head_re    = 1'b0;
    head_raddr = '0;
    ent_we     = 1'b0;
    ent_waddr  = '0;
    ent_wdata  = ent_rdata;
    ent_re     = 1'b0;
    ent_raddr  = '0;
    hash_req   = '0;
    hash_key   = low_bytes(key_bytes_i, kl);

    // result taken downstream
    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end

    case (state_q)
      S_CLEAR: begin
        head_we    = 1'b1;
        head_waddr = clr_q;
        head_wdata = '0;
        clr_d      = clr_q + IW'(1);
        if (&clr_q) begin
          state_d = S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_valid_i) begin
          op_d           = operation_i;
          klen_d         = kl;
          key_d          = low_bytes(key_bytes_i, kl);
          val_d          = low_bytes(value_bytes_i, vl);
          hash_req.start = 1'b1;
          hash_req.len   = kl;
          state_d        = S_HASH;
        end
      end
      S_HASH: begin
        if (hash_done) begin
          hash_d     = hash_val;
          head_re    = 1'b1;
          head_raddr = hash_val[IW-1:0];
          state_d    = S_HEAD_WT;
        end
      end
      S_HEAD_WT: begin
        head_d = head_rdata;
        hit_d  = 1'b0;
        if (head_rdata.ok && (used_q != '0) && (klen_q <= 4'(KEY_BYTES))) begin
          cur_d     = head_rdata.idx;
          ent_re    = 1'b1;
          ent_raddr = head_rdata.idx;
          state_d   = S_WALK;
        end else begin
          state_d = S_DECIDE;
        end
      end
      // chain walk, one entry per cycle
      S_WALK: begin
        if ((ent_rdata.hash == hash_q) && (ent_rdata.key == key_q[KW-1:0])) begin
          hit_d   = 1'b1;
          rec_d   = ent_rdata;
          state_d = S_DECIDE;
        end else if (ent_rdata.next_ok) begin
          cur_d     = ent_rdata.next;
          ent_re    = 1'b1;
          ent_raddr = ent_rdata.next;
        end else begin
          state_d = S_DECIDE;
        end
      end
      S_DECIDE: begin
        res_status_d = STAT_OK;
        res_value_d  = 64'd0;
        res_len_d    = 4'd0;
        state_d      = S_DONE;
        case (op_q)
          OP_GET: begin
            if (hit_q) begin
              res_value_d = rec_q.value;
              res_len_d   = text_len(rec_q.value, 4'd8);
            end else begin
              res_status_d = STAT_NOT_FOUND;
            end
          end
          OP_SET: begin
            if (hit_q) begin
              ent_we          = 1'b1;
              ent_waddr       = cur_q;
              ent_wdata       = rec_q;
              ent_wdata.value = val_q;
            end else if (used_q[IW]) begin
              res_status_d = STAT_FULL;
            end else begin
              // append at the pool end, link in front of the bucket
              nw.hash    = hash_q;
              nw.key     = key_q[KW-1:0];
              nw.value   = val_q;
              nw.prev    = '0;
              nw.prev_ok = 1'b0;
              nw.next    = head_q.idx;
              nw.next_ok = head_q.ok;
              ent_we     = 1'b1;
              ent_waddr  = used_q[IW-1:0];
              ent_wdata  = nw;
              head_we    = 1'b1;
              head_waddr = hash_q[IW-1:0];
              head_wdata = '{ok: 1'b1, idx: used_q[IW-1:0]};
              cur_d      = used_q[IW-1:0];
              used_d     = used_q + UW'(1);
              if (head_q.ok) begin
                ent_re    = 1'b1;
                ent_raddr = head_q.idx;
                state_d   = S_SET_OLD_WR;
              end
            end
          end
          OP_REMOVE: begin
            if (!hit_q) begin
              res_status_d = STAT_NOT_FOUND;
            end else if (rec_q.prev_ok) begin
              ent_re    = 1'b1;
              ent_raddr = rec_q.prev;
              state_d   = S_RM_PREV_WR;
            end else begin
              state_d = S_RM_NEXT_RD;
            end
          end
          default: begin
            res_status_d = STAT_OK;
          end
        endcase
      end
      // old bucket head gets the new entry as its predecessor
      S_SET_OLD_WR: begin
        ent_we            = 1'b1;
        ent_waddr         = head_q.idx;
        ent_wdata.prev    = cur_q;
        ent_wdata.prev_ok = 1'b1;
        state_d           = S_DONE;
      end
      // unlink: predecessor skips the removed entry
      S_RM_PREV_WR: begin
        ent_we            = 1'b1;
        ent_waddr         = rec_q.prev;
        ent_wdata.next    = rec_q.next;
        ent_wdata.next_ok = rec_q.next_ok;
        state_d           = S_RM_NEXT_RD;
      end
      S_RM_NEXT_RD: begin
        if (rec_q.next_ok) begin
          ent_re    = 1'b1;
          ent_raddr = rec_q.next;
          state_d   = S_RM_NEXT_WR;
        end else begin
          state_d = S_RM_HEAD;
        end
      end
      S_RM_NEXT_WR: begin
        ent_we            = 1'b1;
        ent_waddr         = rec_q.next;
        ent_wdata.prev    = rec_q.prev;
        ent_wdata.prev_ok = rec_q.prev_ok;
        state_d           = S_RM_HEAD;
      end
      // bucket head and pool count; fetch the last entry if it must move
      S_RM_HEAD: begin
        if (head_q.ok && (head_q.idx == cur_q)) begin
          head_we    = 1'b1;
          head_waddr = hash_q[IW-1:0];
          head_wdata = '{ok: rec_q.next_ok, idx: rec_q.next};
        end
        used_d = used_q - UW'(1);
        if (IW'(used_q - UW'(1)) == cur_q) begin
          state_d = S_DONE;
        end else begin
          ent_re    = 1'b1;
          ent_raddr = IW'(used_q - UW'(1));
          state_d   = S_RM_LAST_WR;
        end
      end
      S_RM_LAST_WR: begin
        lrec_d    = ent_rdata;
        ent_we    = 1'b1;
        ent_waddr = cur_q;
        ent_wdata = ent_rdata;
        state_d   = S_RM_LP_RD;
      end
      S_RM_LP_RD: begin
        if (lrec_q.prev_ok) begin
          ent_re    = 1'b1;
          ent_raddr = lrec_q.prev;
          state_d   = S_RM_LP_WR;
        end else begin
          state_d = S_RM_LN_RD;
        end
      end
      S_RM_LP_WR: begin
        ent_we         = 1'b1;
        ent_waddr      = lrec_q.prev;
        ent_wdata.next = cur_q;
        state_d        = S_RM_LN_RD;
      end
      S_RM_LN_RD: begin
        if (lrec_q.next_ok) begin
          ent_re    = 1'b1;
          ent_raddr = lrec_q.next;
          state_d   = S_RM_LN_WR;
        end else begin
          state_d = S_RM_LH_RD;
        end
      end
      S_RM_LN_WR: begin
        ent_we         = 1'b1;
        ent_waddr      = lrec_q.next;
        ent_wdata.prev = cur_q;
        state_d        = S_RM_LH_RD;
      end
      S_RM_LH_RD: begin
        head_re    = 1'b1;
        head_raddr = lrec_q.hash[IW-1:0];
        state_d    = S_RM_LH_WR;
      end
      // moved entry may be its bucket's head
      S_RM_LH_WR: begin
        if (head_rdata.ok && (head_rdata.idx == used_q[IW-1:0])) begin
          head_we    = 1'b1;
          head_waddr = lrec_q.hash[IW-1:0];
          head_wdata = '{ok: 1'b1, idx: cur_q};
        end
        state_d = S_DONE;
      end
      // hand the result to the output register once it is free
      S_DONE: begin
        if (!out_valid_q || out_ready_i) begin
          out_valid_d  = 1'b1;
          out_status_d = res_status_q;
          out_value_d  = res_value_q;
          out_len_d    = res_len_q;
          state_d      = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_CLEAR;
      clr_q        <= '0;
      op_q         <= 2'd0;
      key_q        <= 64'd0;
      klen_q       <= 4'd0;
      val_q        <= 64'd0;
      hash_q       <= 32'd0;
      head_q       <= '0;
      cur_q        <= '0;
      rec_q        <= '0;
      lrec_q       <= '0;
      hit_q        <= 1'b0;
      used_q       <= '0;
      res_status_q <= 2'd0;
      res_value_q  <= 64'd0;
      res_len_q    <= 4'd0;
      out_valid_q  <= 1'b0;
      out_status_q <= 2'd0;
      out_value_q  <= 64'd0;
      out_len_q    <= 4'd0;
    end else begin
      state_q      <= state_d;
      clr_q        <= clr_d;
      op_q         <= op_d;
      key_q        <= key_d;
      klen_q       <= klen_d;
      val_q        <= val_d;
      hash_q       <= hash_d;
      head_q       <= head_d;
      cur_q        <= cur_d;
      rec_q        <= rec_d;
      lrec_q       <= lrec_d;
      hit_q        <= hit_d;
      used_q       <= used_d;
      res_status_q <= res_status_d;
      res_value_q  <= res_value_d;
      res_len_q    <= res_len_d;
      out_valid_q  <= out_valid_d;
      out_status_q <= out_status_d;
      out_value_q  <= out_value_d;
      out_len_q    <= out_len_d;
    end
  end

  // value limit register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vmax_q <= 4'd8;
    end else if (cfg_we_i) begin
      vmax_q <= cfg_wdata_i;
    end
  end

  assign in_ready_o     = (state_q == S_IDLE);
  assign out_valid_o    = out_valid_q;
  assign status_o       = out_status_q;
  assign found_value_o  = out_value_q;
  assign found_length_o = out_len_q;

`include "assert_macros.svh"

  `CMH_ASSERT(a_used_bound, used_q <= UW'(ENTRIES), "pool count beyond table size")
  `CMH_ASSERT(a_insert_room, (ent_we && (state_q == S_DECIDE) && !hit_q) |-> !used_q[IW], "insert into a full pool")
  `CMH_ASSERT(a_remove_count, (state_q == S_RM_HEAD) |=> (used_q == UW'($past(used_q) - UW'(1))), "remove did not shrink the pool")
  `CMH_ASSERT(a_head_write_op, (head_we && (state_q != S_CLEAR)) |-> ((op_q == OP_SET) || (op_q == OP_REMOVE)), "bucket head written by a get")
  `CMH_ASSERT_ALWAYS(a_reset_quiet, !rst_ni |-> !out_valid_o, "result shown during reset")

endmodule

>>> tb/chained_hash_map_checker.sv
module chained_hash_map_checker #(
  parameter int unsigned ENTRIES = 256
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [3:0]  cfg_wdata_i,
  input  logic        in_valid_i,
  input  logic        in_ready_i,
  input  logic [1:0]  operation_i,
  input  logic [63:0] key_bytes_i,
  input  logic [3:0]  key_length_i,
  input  logic [63:0] value_bytes_i,
  input  logic [3:0]  value_length_i,
  input  logic        out_valid_i,
  input  logic        out_ready_i,
  input  logic [1:0]  status_i,
  input  logic [63:0] found_value_i,
  input  logic [3:0]  found_length_i,
  output int          errors_o,
  output int          pending_o
);
  timeunit 1ns;
  timeprecision 1ps;
  import cmh_pkg::*;

  typedef struct {
    status_e     status;
    logic [63:0] value;
    logic [3:0]  length;
  } lookup_result_t;

  // shadow copy of the table
  int unsigned bucket_head [ENTRIES];
  bit          head_ok     [ENTRIES];
  bit   [31:0] ent_hash    [ENTRIES];
  bit   [63:0] ent_key     [ENTRIES];
  bit   [63:0] ent_val     [ENTRIES];
  int unsigned ent_prev    [ENTRIES];
  int unsigned ent_next    [ENTRIES];
  bit          prev_ok     [ENTRIES];
  bit          next_ok     [ENTRIES];
  int unsigned used;
  int unsigned max_len;

  lookup_result_t expected_q[$];

  // text length: stops at first zero byte, capped at n and eight
  function automatic int unsigned str_len(logic [63:0] v, int unsigned n);
    int unsigned i;
    i = 0;
    if (n > 8) n = 8;
    while (i < n && v[8*i +: 8] != 8'h00) i++;
    return i;
  endfunction

  function automatic logic [63:0] mask_bytes(logic [63:0] v, int unsigned n);
    logic [63:0] r;
    r = v;
    for (int i = 0; i < 8; i++) begin
      if (i >= n) r[8*i +: 8] = 8'h00;
    end
    return r;
  endfunction

  function automatic logic [31:0] djb_hash(logic [63:0] k, int unsigned n);
    logic [31:0] h;
    h = HASH_SEED;
    for (int i = 0; i < n && i < 8; i++) begin
      h = ((h << HASH_SHIFT) + h) ^ {24'h0, k[8*i +: 8]};
    end
    return h;
  endfunction

  // chain walk from the bucket head
  function automatic bit find_slot(logic [31:0] h, logic [63:0] k, int unsigned n,
                                   output int unsigned slot);
    int unsigned b;
    int unsigned i;
    b = h & (ENTRIES - 1);
    slot = 0;
    if (used == 0 || !head_ok[b] || n > 8) return 0;
    i = bucket_head[b];
    for (int s = 0; s < ENTRIES; s++) begin
      if (i >= ENTRIES) return 0;
      if (ent_hash[i] == h && ent_key[i] == k) begin
        slot = i;
        return 1;
      end
      if (!next_ok[i]) return 0;
      i = ent_next[i];
    end
    return 0;
  endfunction

  // unlink, then move the last pool entry into the hole
  function automatic void drop_slot(int unsigned i);
    int unsigned b;
    int unsigned last;
    b = ent_hash[i] & (ENTRIES - 1);
    if (prev_ok[i] && ent_prev[i] < ENTRIES) begin
      next_ok[ent_prev[i]]  = next_ok[i];
      ent_next[ent_prev[i]] = ent_next[i];
    end
    if (next_ok[i] && ent_next[i] < ENTRIES) begin
      prev_ok[ent_next[i]]  = prev_ok[i];
      ent_prev[ent_next[i]] = ent_prev[i];
    end
    if (head_ok[b] && bucket_head[b] == i) begin
      head_ok[b]     = next_ok[i];
      bucket_head[b] = ent_next[i];
    end
    if (used == 0) return;
    used--;
    last = used;
    if (i == last || last >= ENTRIES) return;
    ent_hash[i] = ent_hash[last];
    ent_key[i]  = ent_key[last];
    ent_val[i]  = ent_val[last];
    ent_prev[i] = ent_prev[last];
    ent_next[i] = ent_next[last];
    prev_ok[i]  = prev_ok[last];
    next_ok[i]  = next_ok[last];
    if (prev_ok[i] && ent_prev[i] < ENTRIES) ent_next[ent_prev[i]] = i;
    if (next_ok[i] && ent_next[i] < ENTRIES) ent_prev[ent_next[i]] = i;
    b = ent_hash[i] & (ENTRIES - 1);
    if (head_ok[b] && bucket_head[b] == last) bucket_head[b] = i;
    prev_ok[last] = 0;
    next_ok[last] = 0;
  endfunction

  // apply one request to the shadow table and give its result
  function automatic lookup_result_t predict(logic [1:0] op, logic [63:0] kraw,
                                             logic [3:0] klraw, logic [63:0] vraw,
                                             logic [3:0] vlraw);
    int unsigned klen;
    int unsigned vlen;
    int unsigned vcap;
    int unsigned slot;
    int unsigned b;
    logic [63:0] k;
    logic [63:0] v;
    logic [31:0] h;
    bit hit;
    lookup_result_t r;
    klen = str_len(kraw, klraw);
    k    = mask_bytes(kraw, klen);
    h    = djb_hash(k, klen);
    vcap = (max_len > 8) ? 8 : max_len;
    vlen = str_len(vraw, vlraw);
    if (vlen > vcap) vlen = vcap;
    hit = find_slot(h, k, klen, slot);
    r.status = STAT_OK;
    r.value  = '0;
    r.length = '0;
    case (op)
      OP_GET: begin
        if (hit) begin
          r.value  = ent_val[slot];
          r.length = 4'(str_len(r.value, 8));
        end else begin
          r.status = STAT_NOT_FOUND;
        end
      end
      OP_SET: begin
        v = mask_bytes(vraw, vlen);
        if (hit) begin
          ent_val[slot] = v;
        end else if (used >= ENTRIES) begin
          r.status = STAT_FULL;
        end else begin
          // new entry goes in front of its chain
          b = h & (ENTRIES - 1);
          slot = used;
          used++;
          ent_hash[slot] = h;
          ent_key[slot]  = k;
          ent_val[slot]  = v;
          prev_ok[slot]  = 0;
          ent_prev[slot] = 0;
          next_ok[slot]  = head_ok[b];
          ent_next[slot] = bucket_head[b];
          if (head_ok[b] && bucket_head[b] < ENTRIES) begin
            ent_prev[bucket_head[b]] = slot;
            prev_ok[bucket_head[b]]  = 1;
          end
          bucket_head[b] = slot;
          head_ok[b]     = 1;
        end
      end
      OP_REMOVE: begin
        if (hit) drop_slot(slot);
        else r.status = STAT_NOT_FOUND;
      end
      default: ;
    endcase
    return r;
  endfunction

  task automatic report(string what);
    $display("%0t chained_hash_map_checker mismatch: %s", $time, what);
    errors_o++;
  endtask

  // watch both channels and the config port
  always @(posedge clk_i or negedge rst_ni) begin
    lookup_result_t e;
    if (!rst_ni) begin
      for (int i = 0; i < ENTRIES; i++) begin
        head_ok[i] = 0;
        prev_ok[i] = 0;
        next_ok[i] = 0;
      end
      used     = 0;
      max_len  = 8;
      errors_o = 0;
      expected_q.delete();
      pending_o = 0;
    end else begin
      if (cfg_we_i) max_len = cfg_wdata_i;
      if (out_valid_i && out_ready_i) begin
        if (expected_q.size() == 0) begin
          report($sformatf("result with nothing expected, status %0d", status_i));
        end else begin
          e = expected_q.pop_front();
          if (status_i !== e.status)
            report($sformatf("status %0d, expected %0d", status_i, e.status));
          if (found_value_i !== e.value)
            report($sformatf("found_value %h, expected %h", found_value_i, e.value));
          if (found_length_i !== e.length)
            report($sformatf("found_length %0d, expected %0d", found_length_i, e.length));
        end
      end
      if (in_valid_i && in_ready_i) begin
        expected_q.push_back(predict(operation_i, key_bytes_i, key_length_i,
                                     value_bytes_i, value_length_i));
      end
      pending_o = expected_q.size();
    end
  end

endmodule

>>> tb/tb_chained_hash_map_engine_top.sv
module tb_chained_hash_map_engine_top;
  timeunit 1ns;
  timeprecision 1ps;
  import cmh_pkg::*;

  // code the block treats as a no-op
  localparam logic [1:0] OP_SPARE = 2'd3;
  localparam int unsigned POOL_KEYS = 40;
  localparam int unsigned FILL_KEYS = 300;
  localparam int unsigned LIMIT     = 1500000;

  logic        clk;
  logic        rst_n;
  logic        cfg_we;
  logic [3:0]  cfg_wdata;
  logic        in_valid;
  logic        in_ready;
  logic [1:0]  operation;
  logic [63:0] key_bytes;
  logic [3:0]  key_length;
  logic [63:0] value_bytes;
  logic [3:0]  value_length;
  logic        out_valid;
  logic        out_ready;
  logic [1:0]  status;
  logic [63:0] found_value;
  logic [3:0]  found_length;

  int          fails;
  int          pending;
  int unsigned cycles;
  int          burst_left;
  bit          long_hold;
  logic [63:0] pool_key [POOL_KEYS];
  logic [3:0]  pool_len [POOL_KEYS];

  chained_hash_map_engine_top i_dut (
    .clk_i          (clk),
    .rst_ni         (rst_n),
    .cfg_we_i       (cfg_we),
    .cfg_wdata_i    (cfg_wdata),
    .in_valid_i     (in_valid),
    .in_ready_o     (in_ready),
    .operation_i    (operation),
    .key_bytes_i    (key_bytes),
    .key_length_i   (key_length),
    .value_bytes_i  (value_bytes),
    .value_length_i (value_length),
    .out_valid_o    (out_valid),
    .out_ready_i    (out_ready),
    .status_o       (status),
    .found_value_o  (found_value),
    .found_length_o (found_length)
  );

  chained_hash_map_checker i_checker (
    .clk_i          (clk),
    .rst_ni         (rst_n),
    .cfg_we_i       (cfg_we),
    .cfg_wdata_i    (cfg_wdata),
    .in_valid_i     (in_valid),
    .in_ready_i     (in_ready),
    .operation_i    (operation),
    .key_bytes_i    (key_bytes),
    .key_length_i   (key_length),
    .value_bytes_i  (value_bytes),
    .value_length_i (value_length),
    .out_valid_i    (out_valid),
    .out_ready_i    (out_ready),
    .status_i       (status),
    .found_value_i  (found_value),
    .found_length_i (found_length),
    .errors_o       (fails),
    .pending_o      (pending)
  );

  // clock
  always begin
    clk = 1'b1;
    #5;
    clk = 1'b0;
    #5;
  end

  // run limit
  always @(posedge clk) begin
    cycles++;
    if (cycles == LIMIT) begin
      $display("[chained_hash_map_engine_top] ERROR");
      $finish;
    end
  end

  // receiver: stall pattern with changing density, one long hold-off
  initial begin
    int pct;
    int span;
    pct  = 100;
    span = 0;
    wait (rst_n);
    forever begin
      @(posedge clk);
      if (long_hold) begin
        long_hold = 0;
        out_ready <= 1'b0;
        repeat (400) @(posedge clk);
      end else begin
        if (span == 0) begin
          span = $urandom_range(50, 300);
          case ($urandom_range(0, 4))
            0, 1: pct = 100;
            2: pct = 75;
            3: pct = 40;
            default: pct = 10;
          endcase
        end
        span--;
        out_ready <= ($urandom_range(0, 99) < pct);
      end
    end
  end

  // offer one item; sender works in bursts with gaps between them
  task automatic send(logic [1:0] op, logic [63:0] k, logic [3:0] kl,
                      logic [63:0] v, logic [3:0] vl);
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = $urandom_range(1, 24);
    end
    in_valid     <= 1'b1;
    operation    <= op;
    key_bytes    <= k;
    key_length   <= kl;
    value_bytes  <= v;
    value_length <= vl;
    do @(posedge clk); while (!in_ready);
    burst_left--;
  endtask

  // register write once every result is back
  task automatic write_max_len(logic [3:0] v);
    in_valid <= 1'b0;
    burst_left = 0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (40) @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= v;
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  function automatic logic [63:0] rand_text(int unsigned n);
    logic [63:0] r;
    r = '0;
    for (int i = 0; i < n && i < 8; i++) r[8*i +: 8] = 8'($urandom_range(1, 255));
    return r;
  endfunction

  // noise in the bytes past the length
  function automatic logic [63:0] add_noise(logic [63:0] t, int unsigned n);
    logic [63:0] r;
    r = t;
    for (int i = n; i < 8; i++) r[8*i +: 8] = 8'($urandom);
    return r;
  endfunction

  function automatic logic [63:0] fill_key(int unsigned i);
    return {40'h0, 8'(8'h41 + i / 26), 8'(8'h41 + i % 26), 8'h7e};
  endfunction

  task automatic random_item();
    logic [1:0]  op;
    logic [63:0] k;
    logic [63:0] v;
    logic [3:0]  kl;
    logic [3:0]  vl;
    int          r;
    int          p;
    r = $urandom_range(0, 99);
    op = (r < 40) ? OP_SET : (r < 75) ? OP_GET : (r < 95) ? OP_REMOVE : OP_SPARE;
    if ($urandom_range(0, 99) < 85) begin
      p  = $urandom_range(0, POOL_KEYS - 1);
      k  = pool_key[p];
      kl = pool_len[p];
      if ($urandom_range(0, 9) == 0) k = add_noise(k, kl);
    end else begin
      k  = {$urandom, $urandom};
      kl = 4'($urandom_range(0, 15));
    end
    vl = ($urandom_range(0, 9) == 0) ? 4'($urandom_range(9, 15)) : 4'($urandom_range(0, 8));
    v  = {$urandom, $urandom};
    if ($urandom_range(0, 3) != 0) v = rand_text(vl);
    send(op, k, kl, v, vl);
  endtask

  // stimulus
  initial begin
    int unsigned left_q[$];
    int          j;
    rst_n        = 1'b0;
    cfg_we       = 1'b0;
    cfg_wdata    = '0;
    in_valid     = 1'b0;
    operation    = OP_GET;
    key_bytes    = '0;
    key_length   = '0;
    value_bytes  = '0;
    value_length = '0;
    out_ready    = 1'b0;
    cycles       = 0;
    burst_left   = 0;
    long_hold    = 0;
    for (int i = 0; i < POOL_KEYS; i++) begin
      pool_len[i] = 4'($urandom_range(0, 8));
      pool_key[i] = rand_text(pool_len[i]);
    end
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: empty table, extremes, embedded zeros, spare code
    send(OP_GET,    64'h0000_0000_0000_6b61, 4'd2, '0, 4'd0);
    send(OP_REMOVE, 64'h0000_0000_0000_6b61, 4'd2, '0, 4'd0);
    send(OP_SET,    '1, 4'd8, '1, 4'd8);
    send(OP_GET,    '1, 4'd8, '0, 4'd0);
    send(OP_SET,    '1, 4'd15, 64'h1122_3344_5566_7788, 4'd15);
    send(OP_GET,    '1, 4'd8, '1, 4'd0);
    send(OP_SET,    '0, 4'd0, 64'h0000_0000_0063_6261, 4'd3);
    send(OP_GET,    64'h1234, 4'd0, '0, 4'd0);
    send(OP_SET,    64'h4141_4100_4242, 4'd8, 64'h3300_3231, 4'd4);
    send(OP_GET,    64'h0000_0000_0000_4242, 4'd2, '0, 4'd0);
    send(OP_SET,    64'h0000_0000_0000_4242, 4'd2, '1, 4'd0);
    send(OP_GET,    64'hffff_0000_0000_4242, 4'd6, '0, 4'd0);
    send(OP_SPARE,  '1, 4'd8, '1, 4'd8);
    send(OP_SET,    64'h0000_0000_0000_0001, 4'd1, 64'h0000_0000_0000_0080, 4'd1);
    send(OP_REMOVE, '1, 4'd8, '0, 4'd0);
    send(OP_GET,    '1, 4'd8, '0, 4'd0);
    send(OP_GET,    64'h0000_0000_0000_0001, 4'd1, '0, 4'd0);
    send(OP_REMOVE, '0, 4'd0, '0, 4'd0);
    send(OP_GET,    '0, 4'd0, '0, 4'd0);
    send(OP_REMOVE, 64'h0000_0000_0000_0001, 4'd1, '0, 4'd0);

    // random traffic under two truncation settings
    write_max_len(4'd3);
    long_hold = 1;
    repeat (600) random_item();
    write_max_len(4'd0);
    repeat (250) random_item();

    // fill the pool past capacity
    write_max_len(4'd15);
    for (int i = 0; i < FILL_KEYS; i++) begin
      send(OP_SET, fill_key(i), 4'd3, rand_text(8), 4'd8);
      if (i % 15 == 0) send(OP_GET, fill_key($urandom_range(0, i)), 4'd3, '0, 4'd0);
    end

    // drain in random order, mixed with lookups
    write_max_len(4'd8);
    for (int i = 0; i < FILL_KEYS; i++) left_q.push_back(i);
    while (left_q.size() != 0) begin
      j = $urandom_range(0, left_q.size() - 1);
      if ($urandom_range(0, 3) == 0)
        send(OP_GET, fill_key($urandom_range(0, FILL_KEYS - 1)), 4'd3, '0, 4'd0);
      send(OP_REMOVE, fill_key(left_q[j]), 4'd3, '0, 4'd0);
      left_q.delete(j);
    end
    repeat (300) random_item();

    // drain and verdict
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (60) @(posedge clk);
    if (fails == 0) begin
      $display("[chained_hash_map_engine_top] OK");
    end else begin
      $display("[chained_hash_map_engine_top] ERROR");
    end
    $finish;
  end

endmodule
